// File: src/plstn_pkg.sv
package plstn_pkg;

	// default grid limits
	localparam int X_PLANES_MAX_DEF = 16;
	localparam int Y_POINTS_MAX_DEF = 16;
	localparam int Z_POINTS_MAX_DEF = 16;

	// fixed field widths
	localparam int VAL_W  = 32;
	localparam int CHG_W  = 48;
	localparam int IDX_W  = 4;
	localparam int GXP_W  = 13;
	localparam int SIZE_W = 5;
	localparam int CFGI_W = 3;
	localparam int SQ_W   = 26;
	localparam int SMAG_W = 34;
	localparam int COEF_W = 58;
	localparam int HALF_W = 29;
	localparam int PP_W   = SMAG_W + HALF_W;

	// configuration register indexes
	localparam logic [CFGI_W-1:0] CFG_DIFFUSIVITY = 3'd0;
	localparam logic [CFGI_W-1:0] CFG_GLOBAL_X    = 3'd1;
	localparam logic [CFGI_W-1:0] CFG_LOCAL_X     = 3'd2;
	localparam logic [CFGI_W-1:0] CFG_Y_POINTS    = 3'd3;
	localparam logic [CFGI_W-1:0] CFG_Z_POINTS    = 3'd4;

	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_APPLY = 2'd1,
		MODE_READ  = 2'd2,
		MODE_CLEAR = 2'd3
	} mode_t;

	// one axis term is worked out in these steps
	typedef enum logic [2:0] {
		PH_DIFF   = 3'd0,
		PH_COEF   = 3'd1,
		PH_MUL_LO = 3'd2,
		PH_MUL_HI = 3'd3,
		PH_ROUND  = 3'd4,
		PH_ACC    = 3'd5
	} phase_t;

	typedef struct packed {
		logic       latch;
		logic       clr;
		logic       fld_wr;
		logic       fld_rd;
		logic [2:0] rd_sel;
		logic       fld_cap;
		logic [2:0] cap_idx;
		logic       chg_rd;
		logic       acc_load;
		logic       chg_wr_zero;
		logic       chg_wr_acc;
		logic       calc;
		phase_t     phase;
		logic [1:0] axis;
		logic       finish;
	} plstn_cmd_t;

	typedef struct packed {
		logic  err;
		mode_t mode;
		logic  zterm;
		logic  clr_last;
	} plstn_stat_t;

endpackage

// File: src/plstn_ram.sv
module plstn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: src/plstn_ctrl.sv
module plstn_ctrl
	import plstn_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  plstn_stat_t stat,
	output plstn_cmd_t  cmd,
	output logic        busy,
	output logic        done
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_READ,
		ST_LOAD,
		ST_CALC,
		ST_WRBACK
	} state_t;

	state_t     state_q;
	logic [2:0] cnt_q;
	phase_t     phase_q;
	logic [1:0] axis_q;
	logic       done_q;
	logic       last_axis;

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign last_axis = (axis_q == 2'd2) || (axis_q == 2'd1 && !stat.zterm);

	always_comb begin
		cmd = '0;
		cmd.phase = phase_q;
		cmd.axis = axis_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
			end
			ST_IDLE: begin
				cmd.latch = start;
			end
			ST_CHECK: begin
				if (stat.err) begin
					cmd.finish = 1'b1;
				end else begin
					unique case (stat.mode)
						MODE_WRITE: begin
							cmd.fld_wr = 1'b1;
							cmd.finish = 1'b1;
						end
						MODE_CLEAR: begin
							cmd.chg_wr_zero = 1'b1;
							cmd.finish = 1'b1;
						end
						MODE_READ: begin
							cmd.chg_rd = 1'b1;
						end
						MODE_APPLY: begin
						end
					endcase
				end
			end
			ST_READ: begin
				cmd.finish = 1'b1;
			end
			ST_LOAD: begin
				cmd.fld_rd = (cnt_q != 3'd7);
				cmd.rd_sel = cnt_q;
				cmd.fld_cap = (cnt_q != 3'd0);
				cmd.cap_idx = cnt_q - 3'd1;
				cmd.chg_rd = (cnt_q == 3'd0);
				cmd.acc_load = (cnt_q == 3'd1);
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
			end
			ST_WRBACK: begin
				cmd.chg_wr_acc = 1'b1;
				cmd.finish = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q <= '0;
			phase_q <= PH_DIFF;
			axis_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			unique case (state_q)
				ST_CLEAR: begin
					if (stat.clr_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (stat.err || stat.mode == MODE_WRITE || stat.mode == MODE_CLEAR) begin
						state_q <= ST_IDLE;
					end else if (stat.mode == MODE_READ) begin
						state_q <= ST_READ;
					end else begin
						state_q <= ST_LOAD;
						cnt_q <= '0;
					end
				end
				ST_READ: begin
					state_q <= ST_IDLE;
				end
				ST_LOAD: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd7) begin
						state_q <= ST_CALC;
						phase_q <= PH_DIFF;
						axis_q <= '0;
					end
				end
				ST_CALC: begin
					if (phase_q == PH_ACC) begin
						phase_q <= PH_DIFF;
						if (last_axis) begin
							state_q <= ST_WRBACK;
						end else begin
							axis_q <= axis_q + 2'd1;
						end
					end else begin
						phase_q <= phase_t'(phase_q + 3'd1);
					end
				end
				ST_WRBACK: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: src/plstn_dp.sv
module plstn_dp
	import plstn_pkg::*;
#(
	parameter int X_PLANES_MAX = X_PLANES_MAX_DEF,
	parameter int Y_POINTS_MAX = Y_POINTS_MAX_DEF,
	parameter int Z_POINTS_MAX = Z_POINTS_MAX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  plstn_cmd_t         cmd,
	output plstn_stat_t        stat,
	input  logic               cfg_we,
	input  logic [CFGI_W-1:0]  cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic [1:0]         mode,
	input  logic [IDX_W-1:0]   x_index,
	input  logic [IDX_W-1:0]   y_index,
	input  logic [IDX_W-1:0]   z_index,
	input  logic signed [VAL_W-1:0] field_value,
	output logic signed [CHG_W-1:0] change_value,
	output logic               error
);

	localparam int DEPTH = X_PLANES_MAX * Y_POINTS_MAX * Z_POINTS_MAX;
	localparam int AW = $clog2(DEPTH);
	localparam int XCW = ($clog2(X_PLANES_MAX + 1) > SIZE_W) ? $clog2(X_PLANES_MAX + 1) : SIZE_W;
	localparam int YCW = ($clog2(Y_POINTS_MAX + 1) > SIZE_W) ? $clog2(Y_POINTS_MAX + 1) : SIZE_W;
	localparam int ZCW = ($clog2(Z_POINTS_MAX + 1) > SIZE_W) ? $clog2(Z_POINTS_MAX + 1) : SIZE_W;
	localparam int DW = GXP_W + 1;
	localparam logic signed [CHG_W:0] SAT_MAX = {2'b00, {(CHG_W-1){1'b1}}};
	localparam logic signed [CHG_W:0] SAT_MIN = {2'b11, {(CHG_W-1){1'b0}}};

	// configuration
	logic [31:0]       diff_q;
	logic [GXP_W-1:0]  gxp_q;
	logic [SIZE_W-1:0] lxp_q, yp_q, zp_q;

	// latched item
	mode_t             mode_q;
	logic [IDX_W-1:0]  x_q, y_q, z_q;
	logic [VAL_W-1:0]  fv_q;

	logic [XCW-1:0] np, xc, xlo, xhi;
	logic [YCW-1:0] ny, yc, ylo, yhi;
	logic [ZCW-1:0] nz, zc, zlo, zhi;
	logic           err;

	logic [AW-1:0] a_c, rd_addr, clr_addr_q, chg_waddr;
	logic          fld_we, chg_we;
	logic [VAL_W-1:0] fld_rdata;
	logic [CHG_W-1:0] chg_rdata, chg_wdata;

	logic signed [VAL_W-1:0] fld_q [7];
	logic signed [CHG_W-1:0] acc_q;
	logic                    neg_q;
	logic [SMAG_W-1:0]       smag_q;
	logic [SQ_W-1:0]         sq_q;
	logic [COEF_W-1:0]       coef_q;
	logic [PP_W-1:0]         p0_q, p1_q;
	logic signed [CHG_W-1:0] term_q;

	logic signed [VAL_W-1:0] lft, rgt;
	logic signed [DW-1:0]    d;
	logic signed [VAL_W+2:0] s;
	logic [PP_W+HALF_W:0]    tot;
	logic [CHG_W:0]          mag;
	logic signed [CHG_W-1:0] term_n;
	logic signed [CHG_W:0]   sum;

	function automatic logic [AW-1:0] cell_addr(input logic [XCW-1:0] xi,
			input logic [YCW-1:0] yi, input logic [ZCW-1:0] zi);
		return AW'((int'(xi) * Y_POINTS_MAX + int'(yi)) * Z_POINTS_MAX + int'(zi));
	endfunction

	// effective sizes and neighbours
	assign np = (XCW'(lxp_q) > XCW'(X_PLANES_MAX)) ? XCW'(X_PLANES_MAX) : XCW'(lxp_q);
	assign ny = (YCW'(yp_q) > YCW'(Y_POINTS_MAX)) ? YCW'(Y_POINTS_MAX) : YCW'(yp_q);
	assign nz = (ZCW'(zp_q) > ZCW'(Z_POINTS_MAX)) ? ZCW'(Z_POINTS_MAX) : ZCW'(zp_q);
	assign xc = XCW'(x_q);
	assign yc = YCW'(y_q);
	assign zc = ZCW'(z_q);
	assign xlo = xc - XCW'(1);
	assign xhi = xc + XCW'(1);
	assign ylo = (yc == '0) ? ny - YCW'(1) : yc - YCW'(1);
	assign yhi = (yc + YCW'(1) == ny) ? '0 : yc + YCW'(1);
	assign zlo = (zc == '0) ? nz - ZCW'(1) : zc - ZCW'(1);
	assign zhi = (zc + ZCW'(1) == nz) ? '0 : zc + ZCW'(1);

	assign err = !(xc < np && yc < ny && zc < nz)
		|| (mode_q == MODE_APPLY && (xc == '0 || xc + XCW'(1) == np));

	assign stat.err = err;
	assign stat.mode = mode_q;
	assign stat.zterm = (nz > ZCW'(1));
	assign stat.clr_last = (clr_addr_q == AW'(DEPTH - 1));

	assign a_c = cell_addr(xc, yc, zc);

	always_comb begin
		unique case (cmd.rd_sel)
			3'd1: rd_addr = cell_addr(xlo, yc, zc);
			3'd2: rd_addr = cell_addr(xhi, yc, zc);
			3'd3: rd_addr = cell_addr(xc, ylo, zc);
			3'd4: rd_addr = cell_addr(xc, yhi, zc);
			3'd5: rd_addr = cell_addr(xc, yc, zlo);
			3'd6: rd_addr = cell_addr(xc, yc, zhi);
			default: rd_addr = a_c;
		endcase
	end

	assign fld_we = cmd.fld_wr;
	assign chg_we = cmd.clr | cmd.chg_wr_zero | cmd.chg_wr_acc;
	assign chg_waddr = cmd.clr ? clr_addr_q : a_c;
	assign chg_wdata = cmd.chg_wr_acc ? acc_q : '0;

	plstn_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_fld_ram (
		.clk   (clk),
		.we    (fld_we),
		.waddr (a_c),
		.wdata (fv_q),
		.raddr (rd_addr),
		.rdata (fld_rdata)
	);

	plstn_ram #(.WIDTH(CHG_W), .DEPTH(DEPTH)) u_chg_ram (
		.clk   (clk),
		.we    (chg_we),
		.waddr (chg_waddr),
		.wdata (chg_wdata),
		.raddr (a_c),
		.rdata (chg_rdata)
	);

	// axis operands
	always_comb begin
		unique case (cmd.axis)
			2'd1: begin
				lft = fld_q[3];
				rgt = fld_q[4];
				d = DW'(ny) - DW'(1);
			end
			2'd2: begin
				lft = fld_q[5];
				rgt = fld_q[6];
				d = DW'(nz) - DW'(1);
			end
			default: begin
				lft = fld_q[1];
				rgt = fld_q[2];
				d = DW'(gxp_q) - DW'(1);
			end
		endcase
	end

	assign s = (VAL_W+3)'(lft) + (VAL_W+3)'(rgt) - ((VAL_W+3)'(fld_q[0]) <<< 1);

	// round half away from zero, clamp magnitude at 2^48
	always_comb begin
		tot = {1'b0, p1_q, {HALF_W{1'b0}}} + (PP_W+HALF_W+1)'(p0_q)
			+ (PP_W+HALF_W+1)'(17'h08000);
		if (tot[PP_W+HALF_W:64] != '0) begin
			mag = {1'b1, {CHG_W{1'b0}}};
		end else begin
			mag = {1'b0, tot[63:16]};
		end
		if (!neg_q) begin
			term_n = (mag > (CHG_W+1)'(SAT_MAX)) ? CHG_W'(SAT_MAX) : CHG_W'(mag);
		end else if (mag > {2'b01, {(CHG_W-1){1'b0}}}) begin
			term_n = CHG_W'(SAT_MIN);
		end else begin
			term_n = CHG_W'(-mag);
		end
	end

	assign sum = (CHG_W+1)'(acc_q) + (CHG_W+1)'(term_q);

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			mode_q <= mode_t'(mode);
			x_q <= x_index;
			y_q <= y_index;
			z_q <= z_index;
			fv_q <= field_value;
		end
		if (cmd.fld_cap) begin
			fld_q[cmd.cap_idx] <= fld_rdata;
		end
		if (cmd.acc_load) begin
			acc_q <= chg_rdata;
		end
		if (cmd.calc) begin
			unique case (cmd.phase)
				PH_DIFF: begin
					neg_q <= s[VAL_W+2];
					smag_q <= s[VAL_W+2] ? SMAG_W'(-s) : SMAG_W'(s);
					sq_q <= SQ_W'(d * d);
				end
				PH_COEF: coef_q <= COEF_W'(diff_q * sq_q);
				PH_MUL_LO: p0_q <= PP_W'(smag_q * coef_q[HALF_W-1:0]);
				PH_MUL_HI: p1_q <= PP_W'(smag_q * coef_q[COEF_W-1:HALF_W]);
				PH_ROUND: term_q <= term_n;
				PH_ACC: begin
					if (sum > SAT_MAX) begin
						acc_q <= CHG_W'(SAT_MAX);
					end else if (sum < SAT_MIN) begin
						acc_q <= CHG_W'(SAT_MIN);
					end else begin
						acc_q <= CHG_W'(sum);
					end
				end
				default: begin
				end
			endcase
		end
		if (cmd.finish) begin
			change_value <= (!err && mode_q == MODE_READ) ? chg_rdata : '0;
			error <= err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diff_q <= '0;
			gxp_q <= GXP_W'(2);
			lxp_q <= SIZE_W'(3);
			yp_q <= SIZE_W'(1);
			zp_q <= SIZE_W'(1);
			clr_addr_q <= '0;
		end else begin
			if (cmd.clr) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_DIFFUSIVITY: diff_q <= cfg_data;
					CFG_GLOBAL_X: gxp_q <= cfg_data[GXP_W-1:0];
					CFG_LOCAL_X: lxp_q <= cfg_data[SIZE_W-1:0];
					CFG_Y_POINTS: yp_q <= cfg_data[SIZE_W-1:0];
					CFG_Z_POINTS: zp_q <= cfg_data[SIZE_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

endmodule

// File: src/periodic_laplacian_stencil.sv
// seven-point laplacian stencil over a local 3d grid with periodic y and z
// commands: pulse start while busy is low; mode, x/y/z index and field_value
//   are sampled at that edge. one result per command: done is high for one
//   cycle with change_value and error; the receiver cannot stall, so results
//   are simply presented and dropped after that cycle
// commands finish in order: write, clear or rejected in the check state, read in
//   a read state after it, apply after the load, calc and write-back states
// apply reads 7 words, one per cycle, through the single read port of the field
//   memory and uses a 6-step term unit shared by the axes; the next command can
//   be accepted in the same cycle that done is shown
// configuration: cfg_valid/cfg_ready write one register per transaction at
//   cfg_index; cfg_ready is always high, write only while no command is pending
// reset: registers go to their defaults, then a clearing pass zeroes the
//   change memory, one word per cycle over every address, with busy held high;
//   field memory contents are undefined until written
module periodic_laplacian_stencil
	import plstn_pkg::*;
#(
	parameter int X_PLANES_MAX = X_PLANES_MAX_DEF,
	parameter int Y_POINTS_MAX = Y_POINTS_MAX_DEF,
	parameter int Z_POINTS_MAX = Z_POINTS_MAX_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// command channel
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              mode,
	input  logic [IDX_W-1:0]        x_index,
	input  logic [IDX_W-1:0]        y_index,
	input  logic [IDX_W-1:0]        z_index,
	input  logic signed [VAL_W-1:0] field_value,
	// result strobe
	output logic                    done,
	output logic signed [CHG_W-1:0] change_value,
	output logic                    error,
	// configuration write channel
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFGI_W-1:0]       cfg_index,
	input  logic [31:0]             cfg_data
);

	plstn_cmd_t  cmd;
	plstn_stat_t stat;

	// config is always accepted
	assign cfg_ready = 1'b1;

	plstn_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	plstn_dp #(
		.X_PLANES_MAX (X_PLANES_MAX),
		.Y_POINTS_MAX (Y_POINTS_MAX),
		.Z_POINTS_MAX (Z_POINTS_MAX)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_we       (cfg_valid & cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mode         (mode),
		.x_index      (x_index),
		.y_index      (y_index),
		.z_index      (z_index),
		.field_value  (field_value),
		.change_value (change_value),
		.error        (error)
	);

endmodule
